FILE: src/rmts_pkg.sv
package rmts_pkg;

  // Task slots in the register file; tasks actually scheduled
  localparam int unsigned SLOTS = 4;
  localparam int unsigned TASKS = 4;
  localparam int unsigned TASK_IDW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned SLOT_IDW = $clog2(SLOTS);

  // Field widths
  localparam int unsigned CNT_W = 8;
  localparam int unsigned TASK_NUM_W = 3;
  localparam int unsigned CFG_IDX_W = 4;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_EXEC_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_END = 4'd8;

  // Register reset values
  localparam logic [CNT_W-1:0] EXEC_RESET = 8'd0;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 8'd1;

  // Task numbers on the result: 0 means none
  localparam logic [TASK_NUM_W-1:0] TASK_NONE = 3'd0;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t [SLOTS-1:0] exec_time;
    cnt_t [SLOTS-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic [TASK_NUM_W-1:0] running_task;
    logic                  deadline_missed;
    logic [TASK_NUM_W-1:0] missed_task;
    logic                  halted;
  } result_t;

endpackage

FILE: src/rmts_cfg_regs.sv
module rmts_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rmts_pkg::CNT_W-1:0]     cfg_data_i,
  output rmts_pkg::cfg_t                 cfg_o
);

  rmts_pkg::cfg_t cfg_q, cfg_d;
  logic [rmts_pkg::CFG_IDX_W-1:0] exec_off, period_off;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  assign exec_off = cfg_index_i - rmts_pkg::CFG_EXEC_BASE;
  assign period_off = cfg_index_i - rmts_pkg::CFG_PERIOD_BASE;

  // Register decode; indexes past the map are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i < rmts_pkg::CFG_PERIOD_BASE) begin
        cfg_d.exec_time[exec_off[rmts_pkg::SLOT_IDW-1:0]] = cfg_data_i;
      end else if (cfg_index_i < rmts_pkg::CFG_REG_END) begin
        cfg_d.period[period_off[rmts_pkg::SLOT_IDW-1:0]] = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rmts_pkg::SLOTS; k++) begin
        cfg_q.exec_time[k] <= rmts_pkg::EXEC_RESET;
        cfg_q.period[k] <= rmts_pkg::PERIOD_RESET;
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/rmts_task_core.sv
module rmts_task_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmts_pkg::cfg_t     cfg_i,
  input  logic               fire_i,
  input  logic               restart_i,
  output rmts_pkg::result_t  result_o
);

  rmts_pkg::cnt_t [rmts_pkg::TASKS-1:0] work_q, work_d, work_eff;
  rmts_pkg::cnt_t [rmts_pkg::TASKS-1:0] left_q, left_d, left_eff;
  logic stopped_q, stopped_d;

  logic                          active;
  logic                          found;
  logic [rmts_pkg::TASK_IDW-1:0] best;
  logic                          miss;
  logic [rmts_pkg::TASK_NUM_W-1:0] miss_num;

  // Restart reloads every task ahead of this tick
  always_comb begin
    for (int k = 0; k < rmts_pkg::TASKS; k++) begin
      work_eff[k] = restart_i ? cfg_i.exec_time[k] : work_q[k];
      left_eff[k] = restart_i ? cfg_i.period[k] : left_q[k];
    end
    active = restart_i || !stopped_q;
  end

  // Pick the ready task with the shortest period, lowest index on ties
  always_comb begin
    found = 1'b0;
    best = '0;
    for (int k = 0; k < rmts_pkg::TASKS; k++) begin
      if (work_eff[k] != '0 &&
          (!found || cfg_i.period[k] < cfg_i.period[best])) begin
        best = rmts_pkg::TASK_IDW'(k);
        found = 1'b1;
      end
    end
  end

  // Run one tick of work, then count periods down; the first miss stops the sweep
  always_comb begin
    work_d = work_eff;
    left_d = left_eff;
    miss = 1'b0;
    miss_num = rmts_pkg::TASK_NONE;
    if (found) begin
      work_d[best] = work_eff[best] - 1'b1;
    end
    for (int k = 0; k < rmts_pkg::TASKS; k++) begin
      if (!miss) begin
        left_d[k] = left_eff[k] - 1'b1;
        if (left_d[k] == '0) begin
          if (work_d[k] != '0) begin
            miss = 1'b1;
            miss_num = rmts_pkg::TASK_NUM_W'(k + 1);
          end else begin
            work_d[k] = cfg_i.exec_time[k];
            left_d[k] = cfg_i.period[k];
          end
        end
      end
    end
    stopped_d = miss;
  end

  // Result of this tick
  always_comb begin
    if (active) begin
      result_o.running_task = found ?
          rmts_pkg::TASK_NUM_W'(best) + rmts_pkg::TASK_NUM_W'(1) : rmts_pkg::TASK_NONE;
      result_o.deadline_missed = miss;
      result_o.missed_task = miss_num;
      result_o.halted = miss;
    end else begin
      result_o.running_task = rmts_pkg::TASK_NONE;
      result_o.deadline_missed = 1'b0;
      result_o.missed_task = rmts_pkg::TASK_NONE;
      result_o.halted = 1'b1;
    end
  end

  // Task state; a halted tick leaves it untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      left_q <= '0;
      stopped_q <= 1'b1;
    end else if (fire_i && active) begin
      work_q <= work_d;
      left_q <= left_d;
      stopped_q <= stopped_d;
    end
  end

`ifndef SYNTHESIS
  a_miss_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.deadline_missed |=> stopped_q)
    else $error("deadline miss did not stop the scheduler");

  a_miss_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> ((result_o.missed_task != rmts_pkg::TASK_NONE) == result_o.deadline_missed))
    else $error("missed task number disagrees with miss flag");

  a_halted_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && stopped_q && !restart_i |-> result_o.running_task == rmts_pkg::TASK_NONE)
    else $error("task ran while halted");

  a_halted_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && stopped_q && !restart_i |=> $stable(work_q) && $stable(left_q) && stopped_q)
    else $error("task state changed while halted");
`endif

endmodule

FILE: src/rate_monotonic_tick_scheduler_top.sv
// Rate-monotonic tick scheduler for four periodic tasks. Each input transfer is one
// time tick; each tick gives exactly one result transfer with the task run (1..4, 0
// idle), the deadline-miss flag and task, and the halted flag. Ticks are taken one
// per clock while out_stall_i is low: a tick is held in the input register, the
// four-way priority compare and all counter updates are done combinationally
// from that register in the cycle the tick moves on, and the result lands in the
// output register. The block comes out of reset halted; a tick with restart set
// reloads all tasks from the execution-time and period registers. Configuration
// writes (indexes 0..3 execution times, 4..7 periods) are always accepted and must
// only be made while no tick is in flight.
module rate_monotonic_tick_scheduler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rmts_pkg::TASK_NUM_W-1:0] running_task_o,
  output logic                            deadline_missed_o,
  output logic [rmts_pkg::TASK_NUM_W-1:0] missed_task_o,
  output logic                            halted_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rmts_pkg::CNT_W-1:0]      cfg_data_i
);

  rmts_pkg::cfg_t    cfg;
  rmts_pkg::result_t result;
  rmts_pkg::result_t res_q;
  logic in_valid_q, restart_q;
  logic out_valid_q;
  logic out_free, fire, in_take;

  rmts_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rmts_task_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .restart_i(restart_q),
    .result_o (result)
  );

  // Handshake: the tick in the input register moves when the output slot frees up
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      restart_q <= restart_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign running_task_o = res_q.running_task;
  assign deadline_missed_o = res_q.deadline_missed;
  assign missed_task_o = res_q.missed_task;
  assign halted_o = res_q.halted;

endmodule
